// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante |-> cons, sampled on the rising edge, off while in reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante |=> cons, sampled on the rising edge, off while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/cres_pkg.sv -----
// ----------------------------------------------------------------------------
// cres_pkg
// Types and constants of the counter rate / EWMA sampler.
// ----------------------------------------------------------------------------
package cres_pkg;

   localparam int IDX_W       = 6;
   localparam int DATA_W      = 64;
   localparam int SHIFT_W     = 5;
   localparam int NS_W        = 30;
   localparam int MUL_W       = 35;             // holds any value up to RATE_LIMIT
   localparam int MUL_LO_W    = 32;
   localparam int MUL_HI_W    = MUL_W - MUL_LO_W;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 320;
   localparam int RSP_TUSER_W = 2;

   localparam logic [NS_W-1:0]    NS_PER_SEC  = 30'd1000000000;
   localparam logic [DATA_W-1:0]  ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
   // largest value that can be scaled by 1e9 without overflow
   localparam logic [DATA_W-1:0]  RATE_LIMIT  = 64'd18446744073;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd3;

   typedef struct packed {
      logic [DATA_W-1:0] smoothed;
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ROUTE,
      ST_MUL_PP,
      ST_MUL_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SM_DIFF,
      ST_SM_APPLY,
      ST_COMMIT
   } state_type;

   typedef enum logic [1:0] {
      RATE_QUOT,
      RATE_PROD,
      RATE_SAT
   } rate_sel_type;

   typedef struct packed {
      logic         load_in;
      logic         eval;
      logic         mul_pp;
      logic         mul_sum;
      logic         mul_from_quot;
      logic         div_start;
      logic         div_from_prod;
      logic         rate_load;
      rate_sel_type rate_sel;
      logic         sm_diff;
      logic         sm_apply;
      logic         commit;
   } cmd_type;

   typedef struct packed {
      logic need_rate;
      logic delta_fits;
      logic div_done;
      logic q_big;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/core/cres_div.sv -----
// ----------------------------------------------------------------------------
// cres_div
// Restoring 64 / 64 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cres_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cres_pkg::DATA_W-1:0]  dividend,
   input  logic [cres_pkg::DATA_W-1:0]  divisor,
   output logic                         done,
   output logic [cres_pkg::DATA_W-1:0]  quotient
);

   localparam int DW    = cres_pkg::DATA_W;
   localparam int CNT_W = $clog2(DW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quot_ff, quot_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [DW:0]      shifted;
   logic [DW:0]      trial;

   always_comb begin
      shifted = {rem_ff, quot_ff[DW-1]};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[DW]) begin
            rem_in  = trial[DW-1:0];
            quot_in = {quot_ff[DW-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DW-1:0];
            quot_in = {quot_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- rtl/core/cres_ctrl.sv -----
// ----------------------------------------------------------------------------
// cres_ctrl
// Sequencer: evaluate a sample; if a rate is due, scale/divide, smooth; commit.
// ----------------------------------------------------------------------------
module cres_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cres_pkg::sts_type sts,
   output cres_pkg::cmd_type cmd
);

   cres_pkg::state_type state_ff, state_in;
   logic                small_ff, small_in;   // delta small enough to scale first

   always_comb begin
      state_in = state_ff;
      small_in = small_ff;
      case (state_ff)
         cres_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = cres_pkg::ST_EVAL;
         end
         cres_pkg::ST_EVAL: begin
            state_in = cres_pkg::ST_ROUTE;
         end
         cres_pkg::ST_ROUTE: begin
            small_in = sts.delta_fits;
            if (!sts.need_rate)       state_in = cres_pkg::ST_COMMIT;
            else if (sts.delta_fits)  state_in = cres_pkg::ST_MUL_PP;
            else                      state_in = cres_pkg::ST_DIV_START;
         end
         cres_pkg::ST_MUL_PP: begin
            state_in = cres_pkg::ST_MUL_SUM;
         end
         cres_pkg::ST_MUL_SUM: begin
            state_in = small_ff ? cres_pkg::ST_DIV_START : cres_pkg::ST_SM_DIFF;
         end
         cres_pkg::ST_DIV_START: begin
            state_in = cres_pkg::ST_DIV_WAIT;
         end
         cres_pkg::ST_DIV_WAIT: begin
            if (sts.div_done) begin
               if (small_ff || sts.q_big) state_in = cres_pkg::ST_SM_DIFF;
               else                       state_in = cres_pkg::ST_MUL_PP;
            end
         end
         cres_pkg::ST_SM_DIFF: begin
            state_in = cres_pkg::ST_SM_APPLY;
         end
         cres_pkg::ST_SM_APPLY: begin
            state_in = cres_pkg::ST_COMMIT;
         end
         cres_pkg::ST_COMMIT: begin
            if (sts.out_free) state_in = cres_pkg::ST_IDLE;
         end
         default: begin
            state_in = cres_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         cres_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         cres_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         cres_pkg::ST_MUL_PP: begin
            cmd.mul_pp        = 1'b1;
            cmd.mul_from_quot = !small_ff;
         end
         cres_pkg::ST_MUL_SUM: begin
            cmd.mul_sum = 1'b1;
            if (!small_ff) begin
               cmd.rate_load = 1'b1;
               cmd.rate_sel  = cres_pkg::RATE_PROD;
            end
         end
         cres_pkg::ST_DIV_START: begin
            cmd.div_start     = 1'b1;
            cmd.div_from_prod = small_ff;
         end
         cres_pkg::ST_DIV_WAIT: begin
            if (sts.div_done && small_ff) begin
               cmd.rate_load = 1'b1;
               cmd.rate_sel  = cres_pkg::RATE_QUOT;
            end else if (sts.div_done && sts.q_big) begin
               cmd.rate_load = 1'b1;
               cmd.rate_sel  = cres_pkg::RATE_SAT;
            end
         end
         cres_pkg::ST_SM_DIFF: begin
            cmd.sm_diff = 1'b1;
         end
         cres_pkg::ST_SM_APPLY: begin
            cmd.sm_apply = 1'b1;
         end
         cres_pkg::ST_COMMIT: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cres_pkg::ST_IDLE;
         small_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         small_ff <= small_in;
      end
   end

endmodule

// ----- rtl/core/cres_dpath.sv -----
// ----------------------------------------------------------------------------
// cres_dpath
// Counter table, delta and interval, 1e9 scaling, divider, EWMA, result beat.
// ----------------------------------------------------------------------------
module cres_dpath #(
   parameter int NUM_COUNTERS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cres_pkg::cmd_type                   cmd,
   output cres_pkg::sts_type                   sts,
   input  logic [cres_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [0:0]                          req_tuser,
   input  logic                                csr_wr_en,
   input  logic [cres_pkg::SHIFT_W-1:0]        csr_wr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cres_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [cres_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);

   localparam int DW     = cres_pkg::DATA_W;
   localparam int IW     = cres_pkg::IDX_W;
   localparam int REACH  = 2 ** IW;
   localparam int DEPTH  = (NUM_COUNTERS < REACH) ? NUM_COUNTERS : REACH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LO_W   = cres_pkg::MUL_LO_W;
   localparam int HI_W   = cres_pkg::MUL_HI_W;
   localparam int NS_W   = cres_pkg::NS_W;

   // request unpacking
   logic [IW-1:0]     req_idx;
   logic [DW-1:0]     req_value;
   logic [DW-1:0]     req_stamp;
   logic [ADDR_W-1:0] req_addr;

   assign req_idx   = req_tdata[IW-1:0];
   assign req_value = req_tdata[IW+DW-1:IW];
   assign req_stamp = req_tdata[IW+2*DW-1:IW+DW];
   assign req_addr  = req_idx[ADDR_W-1:0];

   // table
   cres_pkg::entry_type mem_ff [DEPTH];
   cres_pkg::entry_type rd_ff;
   logic [DEPTH-1:0]    seen_ff, seen_in;
   logic                seen_rd_ff;

   // sample registers
   logic [IW-1:0]  idx_ff;
   logic [DW-1:0]  val_ff;
   logic [DW-1:0]  ts_ff;
   logic           ok_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic           in_range;

   // evaluation
   logic [DW-1:0]  last_val, last_ts, last_sm, cur_val;
   logic           advance, dec;
   logic [DW-1:0]  delta_ff, intv_ff, sm_old_ff, sm_new_ff, rate_ff;
   logic           dvalid_ff, crst_ff;

   // scaling and division
   logic [cres_pkg::MUL_W-1:0] mul_op;
   logic [LO_W+NS_W-1:0]       pp_lo_ff;
   logic [HI_W+NS_W-1:0]       pp_hi_ff;
   logic [DW-1:0]              prod_sum, prod_ff;
   logic [DW-1:0]              div_num, quotient;
   logic                       div_done;

   // smoothing
   logic [cres_pkg::SHIFT_W-1:0] shift_ff, shift_in, shift_eff;
   logic [DW-1:0]                diff_ff, step;
   logic                         up_ff, zero_ff;

   // totals and result beat
   logic [DW-1:0] err_cnt_ff, err_cnt_in, rst_cnt_ff, rst_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [cres_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [cres_pkg::RSP_TUSER_W-1:0] rsp_user_ff;
   cres_pkg::entry_type entry_wr;

   assign addr_ff  = idx_ff[ADDR_W-1:0];
   assign in_range = ({1'b0, idx_ff} < (IW + 1)'(DEPTH));

   // a counter without a baseline reads as all zero
   always_comb begin
      last_val = seen_rd_ff ? rd_ff.value    : '0;
      last_ts  = seen_rd_ff ? rd_ff.stamp    : '0;
      last_sm  = seen_rd_ff ? rd_ff.smoothed : '0;
      cur_val  = ok_ff ? val_ff : last_val;
      advance  = in_range && seen_rd_ff && (ts_ff > last_ts);
      dec      = cur_val < last_val;
   end

   assign mul_op   = cmd.mul_from_quot ? quotient[cres_pkg::MUL_W-1:0]
                                       : delta_ff[cres_pkg::MUL_W-1:0];
   assign prod_sum = DW'(pp_lo_ff) + {pp_hi_ff[DW-LO_W-1:0], {LO_W{1'b0}}};
   assign div_num  = cmd.div_from_prod ? prod_ff : delta_ff;

   cres_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (intv_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign shift_eff = (shift_ff > cres_pkg::SHIFT_MAX) ? cres_pkg::SHIFT_MAX : shift_ff;
   assign step      = diff_ff >> shift_eff;

   assign entry_wr.value    = val_ff;
   assign entry_wr.stamp    = ts_ff;
   assign entry_wr.smoothed = sm_new_ff;

   // control registers
   always_comb begin
      shift_in     = csr_wr_en ? csr_wr_data : shift_ff;
      seen_in      = seen_ff;
      err_cnt_in   = err_cnt_ff;
      rst_cnt_in   = rst_cnt_ff;
      if (cmd.commit) begin
         if (in_range) seen_in[addr_ff] = 1'b1;
         err_cnt_in = err_cnt_ff + DW'(!ok_ff);
         rst_cnt_in = rst_cnt_ff + DW'(crst_ff);
      end
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= cres_pkg::SHIFT_RESET;
         seen_ff      <= '0;
         err_cnt_ff   <= '0;
         rst_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         seen_ff      <= seen_in;
         err_cnt_ff   <= err_cnt_in;
         rst_cnt_ff   <= rst_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && in_range) mem_ff[addr_ff] <= entry_wr;
      if (cmd.load_in)            rd_ff <= mem_ff[req_addr];
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         idx_ff     <= req_idx;
         val_ff     <= req_value;
         ts_ff      <= req_stamp;
         ok_ff      <= req_tuser[0];
         seen_rd_ff <= seen_ff[req_addr];
      end
      if (cmd.eval) begin
         val_ff    <= cur_val;
         dvalid_ff <= advance;
         crst_ff   <= advance && dec;
         delta_ff  <= (advance && !dec) ? (cur_val - last_val) : '0;
         intv_ff   <= ts_ff - last_ts;
         sm_old_ff <= in_range ? last_sm : '0;
         sm_new_ff <= in_range ? last_sm : '0;
         rate_ff   <= '0;
      end
      if (cmd.mul_pp) begin
         pp_lo_ff <= mul_op[LO_W-1:0] * cres_pkg::NS_PER_SEC;
         pp_hi_ff <= mul_op[cres_pkg::MUL_W-1:LO_W] * cres_pkg::NS_PER_SEC;
      end
      if (cmd.mul_sum) prod_ff <= prod_sum;
      if (cmd.rate_load) begin
         case (cmd.rate_sel)
            cres_pkg::RATE_QUOT: rate_ff <= quotient;
            cres_pkg::RATE_PROD: rate_ff <= prod_sum;
            cres_pkg::RATE_SAT:  rate_ff <= cres_pkg::ALL_ONES;
            default:             rate_ff <= '0;
         endcase
      end
      if (cmd.sm_diff) begin
         zero_ff <= (sm_old_ff == '0);
         up_ff   <= (rate_ff >= sm_old_ff);
         diff_ff <= (rate_ff >= sm_old_ff) ? (rate_ff - sm_old_ff) : (sm_old_ff - rate_ff);
      end
      if (cmd.sm_apply) begin
         sm_new_ff <= zero_ff ? rate_ff : (up_ff ? sm_old_ff + step : sm_old_ff - step);
      end
      if (cmd.commit) begin
         rsp_data_ff <= {err_cnt_in, rst_cnt_in, sm_new_ff, rate_ff, delta_ff};
         rsp_user_ff <= {crst_ff, dvalid_ff};
      end
   end

   assign sts.need_rate  = dvalid_ff;
   assign sts.delta_fits = (delta_ff <= cres_pkg::RATE_LIMIT);
   assign sts.div_done   = div_done;
   assign sts.q_big      = (quotient > cres_pkg::RATE_LIMIT);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/core/counter_rate_ewma_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// counter_rate_ewma_sampler_unit
// Per-counter delta, per-second rate and EWMA from absolute counter samples.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one beat per sample (counter index, absolute value,
//    nanosecond timestamp, read-ok flag). Accepted when tvalid && tready.
//  - rsp_ channel: exactly one result beat per sample, in order.
//  - csr_: write enable plus 5-bit EWMA shift (values above 16 act as 16);
//    write only while the block is idle.
//  - Path, accept to result: evaluate, route, commit when no rate is formed
//    (first sample, stale timestamp, index out of range); when a rate is
//    formed, the 64-step bit-serial divider, the 1e9 multiply (partial
//    products, then sum) and the smoothing step come before commit; the
//    multiply is skipped when the divide-first rate saturates.
//  - One sample in flight at a time: req_tready returns the cycle after the
//    result is loaded into the output register, so a new sample is taken
//    only once the last one is committed.
//  - Reset: per-counter baseline flags all clear at once, so every table
//    entry reads as zero until first written; no clearing pass. Totals go
//    to zero and the shift to 3.
//  - Receiver stall: the result beat holds in its register; the next sample
//    is still taken and worked on, and waits at commit until the beat goes.
// ----------------------------------------------------------------------------
module counter_rate_ewma_sampler_unit #(
   parameter int NUM_COUNTERS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // sample in
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [5:0] counter_index, [69:6] counter_value, [133:70] timestamp_ns, pad
   input  logic [cres_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] read_ok
   input  logic [0:0]                       req_tuser,
   // result out
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [63:0] delta, [127:64] rate_per_sec, [191:128] smoothed_rate,
   // [255:192] reset_total, [319:256] error_total
   output logic [cres_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] delta_valid, [1] counter_reset
   output logic [cres_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // EWMA shift register
   input  logic                             csr_wr_en,
   input  logic [cres_pkg::SHIFT_W-1:0]     csr_wr_data
);

   cres_pkg::cmd_type cmd;   // sequencer -> datapath
   cres_pkg::sts_type sts;   // datapath -> sequencer

   // sequencer: one state per step, waits on divider and on output space
   cres_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: table memory, arithmetic, totals and the result register
   cres_dpath #(
      .NUM_COUNTERS (NUM_COUNTERS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- rtl/core/cres_checker.sv -----
// ----------------------------------------------------------------------------
// cres_checker
// Port-level checks on the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cres_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [cres_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [cres_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   // stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed under stall")

   // one sample at a time: no back-to-back accepts
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "sample accepted while another is in flight")

   // no rate formed: delta, rate and reset flag are all zero
   `ASSERT_IMP(a_no_rate_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[127:0] == '0 && !rsp_tuser[1], "fields set without a valid delta")

   // a counter reset comes with a valid, zero delta
   `ASSERT_IMP(a_reset_zero_delta, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0] && rsp_tdata[63:0] == '0, "counter reset with non-zero delta")

endmodule

bind counter_rate_ewma_sampler_unit cres_checker u_cres_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for counter_rate_ewma_sampler_unit. A short table of
// hand-picked samples is followed by random per-counter histories under
// several EWMA shift settings. Expected beats come from an in-bench
// predictor or a hand-written row, matched field by field to the result stream.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          COUNTERS       = 64;
   localparam logic [63:0] NANOS_PER_SEC  = 64'd1000000000;
   localparam logic [63:0] SCALE_CAP      = 64'd18446744073;   // (2^64-1)/1e9
   localparam logic [63:0] SAT_RATE       = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [4:0]  SHIFT_AT_RESET = 5'd3;
   localparam logic [4:0]  SHIFT_CLAMP    = 5'd16;
   localparam int          PHASE_ITEMS    = 333;
   localparam int          LONG_HOLD      = 400;
   localparam int          STALL_LIMIT    = 4000;
   localparam int          TAIL_CYCLES    = 100;
   localparam int          MAX_PRINTS     = 40;

   // one result beat, in the order the fields are listed for the block
   typedef struct packed {
      logic        delta_valid;
      logic [63:0] delta;
      logic [63:0] rate;
      logic [63:0] smoothed;
      logic        counter_reset;
      logic [63:0] reset_total;
      logic [63:0] error_total;
   } sample_result_type;

   typedef struct packed {
      logic [5:0]        idx;
      logic [63:0]       value;
      logic [63:0]       stamp;
      logic              ok;
      logic              typed;     // want below is hand-written
      sample_result_type want;
   } stim_row_type;

   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // directed samples; shift is still at its reset value of 3 here
   localparam stim_row_type DIRECTED [18] = '{
      // first sample of counter 0 only sets the baseline
      '{6'd0, 64'd100, 64'd1000, 1'b1, 1'b1, '{1'b0, 64'd0, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0}},
      // +1000 in 1000 ns, empty average takes the rate
      '{6'd0, 64'd1100, 64'd2000, 1'b1, 1'b1,
        '{1'b1, 64'd1000, 64'd1000000000, 64'd1000000000, 1'b0, 64'd0, 64'd0}},
      // value goes backwards: zero delta, counter reset
      '{6'd0, 64'd50, 64'd3000, 1'b1, 1'b1,
        '{1'b1, 64'd0, 64'd0, 64'd875000000, 1'b1, 64'd1, 64'd0}},
      // same timestamp: refresh only
      '{6'd0, 64'd60, 64'd3000, 1'b1, 1'b1,
        '{1'b0, 64'd0, 64'd0, 64'd875000000, 1'b0, 64'd1, 64'd0}},
      // failed read reuses the stored 60
      '{6'd0, ONES, 64'd4000, 1'b0, 1'b1,
        '{1'b1, 64'd0, 64'd0, 64'd765625000, 1'b0, 64'd1, 64'd1}},
      // failed read before any baseline: value taken as zero
      '{6'd1, 64'd12345, 64'd0, 1'b0, 1'b1,
        '{1'b0, 64'd0, 64'd0, 64'd0, 1'b0, 64'd1, 64'd2}},
      // full-scale delta in 1 ns saturates the rate
      '{6'd1, ONES, 64'd1, 1'b1, 1'b1, '{1'b1, ONES, ONES, ONES, 1'b0, 64'd1, 64'd2}},
      '{6'd1, ONES, ONES, 1'b1, 1'b0, '0},
      '{6'd63, 64'd0, 64'd0, 1'b1, 1'b1, '{1'b0, 64'd0, 64'd0, 64'd0, 1'b0, 64'd1, 64'd2}},
      // largest delta on the multiply-first path
      '{6'd63, SCALE_CAP, 64'd1000000000, 1'b1, 1'b0, '0},
      // one above it: divide-first path
      '{6'd63, 64'd36893488147, 64'd1000001000, 1'b1, 1'b0, '0},
      '{6'd63, ONES, ONES, 1'b1, 1'b0, '0},
      '{6'd63, 64'd0, 64'd5, 1'b1, 1'b0, '0},
      '{6'd63, 64'd0, ONES, 1'b0, 1'b0, '0},
      '{6'd2, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0},
      '{6'd2, 64'hAAAA_AAAA_AAAA_AAAA, ONES, 1'b1, 1'b0, '0},
      '{6'd32, 64'd1, 64'd1, 1'b1, 1'b0, '0},
      '{6'd32, 64'd0, 64'd2, 1'b1, 1'b0, '0}
   };

   // shift per random phase; the fifth entry is replaced by a random draw
   localparam logic [4:0] SHIFT_PLAN [6] = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd0, 5'd1};

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [cres_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [0:0]                       req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [cres_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [cres_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                             csr_wr_en;
   logic [cres_pkg::SHIFT_W-1:0]     csr_wr_data;

   // predictor state
   logic [63:0]    prev_value [COUNTERS];
   logic [63:0]    prev_stamp [COUNTERS];
   logic [63:0]    ewma       [COUNTERS];
   logic           seen       [COUNTERS];
   logic [63:0]    reset_tally;
   logic [63:0]    error_tally;
   logic [4:0]     shift_reg;

   sample_result_type pending [$];   // expected beats, oldest first
   int             fail_count   = 0;
   int             beat_no      = 0;
   int             quiet_cycles = 0;
   int             hold_reqs    = 0;   // long hold-offs asked of the receiver
   bit             send_quiet;
   bit             recv_quiet;

   counter_rate_ewma_sampler_unit #(
      .NUM_COUNTERS(COUNTERS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Advances the predictor by one accepted sample and returns its beat.
   function automatic sample_result_type predict_sample(input logic [5:0] idx,
                                                        input logic [63:0] val,
                                                        input logic [63:0] ts,
                                                        input logic ok);
      sample_result_type r;
      logic [63:0]    v;
      logic [63:0]    span;
      logic [63:0]    quot;
      logic [4:0]     sh;
      r  = '0;
      v  = val;
      sh = (shift_reg > SHIFT_CLAMP) ? SHIFT_CLAMP : shift_reg;
      if (!ok) error_tally++;
      if (idx < COUNTERS) begin
         if (!ok) v = seen[idx] ? prev_value[idx] : 64'd0;
         if (!seen[idx]) begin
            seen[idx] = 1'b1;
         end else if (ts > prev_stamp[idx]) begin
            span = ts - prev_stamp[idx];
            if (v >= prev_value[idx]) begin
               r.delta = v - prev_value[idx];
            end else begin
               r.counter_reset = 1'b1;
               reset_tally++;
            end
            // multiply first while the product fits, else divide first
            if (r.delta != 64'd0) begin
               if (r.delta <= SCALE_CAP) begin
                  r.rate = (r.delta * NANOS_PER_SEC) / span;
               end else begin
                  quot   = r.delta / span;
                  r.rate = (quot > SCALE_CAP) ? SAT_RATE : quot * NANOS_PER_SEC;
               end
            end
            if (ewma[idx] == 64'd0)
               ewma[idx] = r.rate;
            else if (r.rate >= ewma[idx])
               ewma[idx] = ewma[idx] + ((r.rate - ewma[idx]) >> sh);
            else
               ewma[idx] = ewma[idx] - ((ewma[idx] - r.rate) >> sh);
            r.delta_valid = 1'b1;
         end
         prev_value[idx] = v;
         prev_stamp[idx] = ts;
         r.smoothed      = ewma[idx];
      end
      r.reset_total = reset_tally;
      r.error_total = error_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want_v);
      if (fail_count < MAX_PRINTS)
         $display("tb: beat %0d %s: got %h, want %h", beat_no, field, got, want_v);
      fail_count++;
   endtask

   // Offers one sample beat; returns at the falling edge after acceptance.
   // Valid is only lowered when a gap follows, so it never toggles in one step.
   task automatic send_sample(input logic [5:0] idx, input logic [63:0] val,
                              input logic [63:0] ts, input logic ok,
                              input logic typed, input sample_result_type typed_want);
      int                gap;
      sample_result_type predicted;
      gap = send_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, ts, val, idx};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      predicted = predict_sample(idx, val, ts, ok);
      pending.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   // Shift register writes only once every expected beat is back.
   task automatic write_shift(input logic [4:0] v);
      while (pending.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shift_reg   = v;
   endtask

   // Receiver: a fresh stall before every beat, and one long hold-off on request
   // so the block fills up and pushes back on the sample side.
   initial begin : rsp_side
      int stall;
      int hold_done;
      hold_done  = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_reqs != hold_done) begin
            stall     = LONG_HOLD;
            hold_done = hold_reqs;
         end else begin
            stall = recv_quiet ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result checker: every accepted beat against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      sample_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            report_mismatch("beat with nothing expected", 64'd0, 64'd0);
         end else begin
            want = pending.pop_front();
            if (rsp_tuser[0] !== want.delta_valid)
               report_mismatch("delta_valid", 64'(rsp_tuser[0]), 64'(want.delta_valid));
            if (rsp_tuser[1] !== want.counter_reset)
               report_mismatch("counter_reset", 64'(rsp_tuser[1]), 64'(want.counter_reset));
            if (rsp_tdata[63:0] !== want.delta)
               report_mismatch("delta", rsp_tdata[63:0], want.delta);
            if (rsp_tdata[127:64] !== want.rate)
               report_mismatch("rate_per_sec", rsp_tdata[127:64], want.rate);
            if (rsp_tdata[191:128] !== want.smoothed)
               report_mismatch("smoothed_rate", rsp_tdata[191:128], want.smoothed);
            if (rsp_tdata[255:192] !== want.reset_total)
               report_mismatch("reset_total", rsp_tdata[255:192], want.reset_total);
            if (rsp_tdata[319:256] !== want.error_total)
               report_mismatch("error_total", rsp_tdata[319:256], want.error_total);
         end
         beat_no++;
      end
   end

   // Watchdog: too long without a beat on either side ends the run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int          ph;
      int          n;
      int          kind;
      logic [5:0]  idx;
      logic [63:0] val;
      logic [63:0] ts;
      logic [63:0] step;
      logic [63:0] span;
      logic        ok;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      send_quiet  = 1'b0;
      recv_quiet  = 1'b0;
      for (int i = 0; i < COUNTERS; i++) begin
         prev_value[i] = '0;
         prev_stamp[i] = '0;
         ewma[i]       = '0;
         seen[i]       = 1'b0;
      end
      reset_tally = '0;
      error_tally = '0;
      shift_reg   = SHIFT_AT_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset shift
      foreach (DIRECTED[i])
         send_sample(DIRECTED[i].idx, DIRECTED[i].value, DIRECTED[i].stamp,
                     DIRECTED[i].ok, DIRECTED[i].typed, DIRECTED[i].want);

      // random histories, one shift setting per phase
      for (ph = 0; ph < 6; ph++) begin
         req_tvalid <= 1'b0;
         write_shift(ph == 4 ? 5'($urandom_range(0, 31)) : SHIFT_PLAN[ph]);
         if (ph == 0 || $urandom_range(0, 2) == 0) hold_reqs++;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0) begin
               send_quiet = ($urandom_range(0, 3) == 0);
               recv_quiet = ($urandom_range(0, 3) == 0);
            end
            // mostly a few hot counters so histories get long
            idx = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7))
                                             : 6'($urandom_range(0, 63));
            case ($urandom_range(0, 3))
               0:       step = 64'($urandom_range(0, 1000));
               1:       step = 64'($urandom);
               2:       step = rand64() >> $urandom_range(8, 63);
               default: step = rand64() >> $urandom_range(0, 7);
            endcase
            case ($urandom_range(0, 2))
               0:       span = 64'($urandom_range(1, 1000));
               1:       span = 64'($urandom_range(1, 2000000000));
               default: span = (rand64() >> $urandom_range(20, 63)) + 64'd1;
            endcase
            val  = prev_value[idx] + step;
            ts   = prev_stamp[idx] + span;
            ok   = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 4) begin
               // noise: anything at all
               val = rand64();
               ts  = rand64();
               ok  = 1'($urandom_range(0, 1));
            end else if (kind < 10) begin
               ok  = 1'b0;
               val = rand64();
            end else if (kind < 15) begin
               ts = prev_stamp[idx] - 64'($urandom_range(0, 3));
            end else if (kind < 20) begin
               val = prev_value[idx] - 64'($urandom_range(1, 1000));
            end
            send_sample(idx, val, ts, ok, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      send_quiet = 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- counter_rate_ewma_sampler_unit.f -----
+incdir+rtl/core
rtl/core/cres_pkg.sv
rtl/core/cres_div.sv
rtl/core/cres_ctrl.sv
rtl/core/cres_dpath.sv
rtl/core/counter_rate_ewma_sampler_unit.sv
rtl/core/cres_checker.sv
test/testbench.sv
